// ===== rtl/mexp_pkg.sv =====
// Shared constants and types for the modular exponentiation block.
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

   // Width of the arithmetic; only the low VALUE_BITS bits of each value are used
   localparam int VALUE_BITS = 32;
   localparam int CNT_W      = $clog2(VALUE_BITS);

   // Configuration register map
   localparam int          CSR_IDX_W    = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPONENT = 1'b1;

   localparam logic [31:0] MODULUS_RESET  = 32'd257;
   localparam logic [31:0] EXPONENT_RESET = 32'd1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_MUL,
      ST_SQR,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/modular_exponentiation.sv =====
// Modular exponentiation by right-to-left square-and-multiply over one shared mod-multiplier.
//
// Usage:
//   req_valid/req_stall carry one base value; rsp_valid/rsp_stall return
//   base ^ exponent mod modulus for it. The csr_ port writes the modulus
//   (index 0) and the exponent (index 1); write only while the block is idle.
// Timing:
//   One interleaved modular multiplier processes one multiplier bit per cycle,
//   so each modular multiply steps through all VALUE_BITS (32) multiplier bits.
//   An item costs one multiply to reduce the base, then one square per
//   exponent bit up to the highest set bit (minus one) and one multiply per
//   set bit: at most 64 multiplies. A modulus below 2 skips the arithmetic
//   and gives zero; a zero exponent costs only the reduction.
//   One item is in work at a time; req_stall is high while it is in progress.
// Stall and reset:
//   The result sits in an output register; a new item may be taken while it
//   waits, but the next result is held in the sequencer until rsp_stall drops.
//   Reset empties the output, returns to idle and restores modulus 257, exponent 1.
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // input channel
   input  wire logic                             req_valid,
   output      logic                             req_stall,
   input  wire logic [31:0]                      req_base_value,
   // result channel
   output      logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   output      logic [31:0]                      rsp_power_result,
   // configuration port
   input  wire logic                             csr_write,
   input  wire logic [mexp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [31:0]                      csr_data
);

   localparam int VB = mexp_pkg::VALUE_BITS;
   localparam int CW = mexp_pkg::CNT_W;

   // configuration registers
   logic [31:0] modulus_ff;
   logic [31:0] exponent_ff;

   // sequencer and datapath registers
   mexp_pkg::state_type state_ff, state_in;
   logic [VB-1:0] acc_ff,   acc_in;
   logic [VB-1:0] base_ff,  base_in;
   logic [VB-1:0] exp_ff,   exp_in;
   logic [VB-1:0] mod_ff,   mod_in;
   logic [VB-1:0] mul_b_ff, mul_b_in;
   logic [VB-1:0] mul_r_ff, mul_r_in;
   logic [CW-1:0] cnt_ff,   cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [VB-1:0] rsp_data_ff,  rsp_data_in;

   // shared unit signals
   logic [VB-1:0] mul_a;
   logic [VB:0]   dbl;
   logic [VB:0]   dbl_red;
   logic [VB:0]   sum;
   logic [VB-1:0] step_r;
   logic          op_done;

   // configuration write decode
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= mexp_pkg::MODULUS_RESET;
         exponent_ff <= mexp_pkg::EXPONENT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            mexp_pkg::CSR_MODULUS:  modulus_ff  <= csr_data;
            mexp_pkg::CSR_EXPONENT: exponent_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // interleaved modular multiply step: r = 2r + b_msb * a  (mod m)
   always_comb begin
      mul_a   = (state_ff == mexp_pkg::ST_REDUCE) ? VB'(1) : base_ff;
      dbl     = {mul_r_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, mod_ff}) ? dbl - {1'b0, mod_ff} : dbl;
      sum     = dbl_red + (mul_b_ff[VB-1] ? {1'b0, mul_a} : '0);
      step_r  = (sum >= {1'b0, mod_ff}) ? VB'(sum - {1'b0, mod_ff}) : VB'(sum);
      op_done = (cnt_ff == CW'(VB - 1));
   end

   // sequencer: next state and datapath loads
   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      mod_in       = mod_ff;
      mul_b_in     = {mul_b_ff[VB-2:0], 1'b0};
      mul_r_in     = step_r;
      cnt_in       = cnt_ff + CW'(1);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      req_stall    = (state_ff != mexp_pkg::ST_IDLE);

      unique case (state_ff)
         mexp_pkg::ST_IDLE: begin
            mul_b_in = mul_b_ff;
            mul_r_in = mul_r_ff;
            cnt_in   = cnt_ff;
            if (req_valid) begin
               mod_in = modulus_ff[VB-1:0];
               exp_in = exponent_ff[VB-1:0];
               if (modulus_ff[VB-1:0] < VB'(2)) begin
                  // every value is zero modulo one; modulus zero also gives zero
                  acc_in   = '0;
                  state_in = mexp_pkg::ST_DONE;
               end else begin
                  acc_in   = VB'(1);
                  mul_b_in = req_base_value[VB-1:0];
                  mul_r_in = '0;
                  cnt_in   = '0;
                  state_in = mexp_pkg::ST_REDUCE;
               end
            end
         end

         mexp_pkg::ST_REDUCE: begin
            if (op_done) begin
               base_in  = step_r;
               mul_r_in = '0;
               cnt_in   = '0;
               if (exp_ff == '0) begin
                  state_in = mexp_pkg::ST_DONE;
               end else if (exp_ff[0]) begin
                  mul_b_in = acc_ff;
                  state_in = mexp_pkg::ST_MUL;
               end else begin
                  mul_b_in = step_r;
                  state_in = mexp_pkg::ST_SQR;
               end
            end
         end

         mexp_pkg::ST_MUL: begin
            if (op_done) begin
               acc_in   = step_r;
               mul_r_in = '0;
               cnt_in   = '0;
               // last set bit: the final square is not needed
               if (exp_ff[VB-1:1] == '0) begin
                  state_in = mexp_pkg::ST_DONE;
               end else begin
                  mul_b_in = base_ff;
                  state_in = mexp_pkg::ST_SQR;
               end
            end
         end

         mexp_pkg::ST_SQR: begin
            if (op_done) begin
               base_in  = step_r;
               exp_in   = {1'b0, exp_ff[VB-1:1]};
               mul_r_in = '0;
               cnt_in   = '0;
               if (exp_ff[VB-1:1] == '0) begin
                  state_in = mexp_pkg::ST_DONE;
               end else if (exp_ff[1]) begin
                  mul_b_in = acc_ff;
                  state_in = mexp_pkg::ST_MUL;
               end else begin
                  mul_b_in = step_r;
                  state_in = mexp_pkg::ST_SQR;
               end
            end
         end

         mexp_pkg::ST_DONE: begin
            mul_b_in = mul_b_ff;
            mul_r_in = mul_r_ff;
            cnt_in   = cnt_ff;
            // hand the result over once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
               state_in     = mexp_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = mexp_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mexp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      base_ff     <= base_in;
      exp_ff      <= exp_in;
      mod_ff      <= mod_in;
      mul_b_ff    <= mul_b_in;
      mul_r_ff    <= mul_r_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = 32'(rsp_data_ff);

endmodule

`default_nettype wire

// ===== dv/mexp_checker.sv =====
// Checker for the modular exponentiation block: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module mexp_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_stall,
   input  wire logic [31:0]                    req_base_value,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   input  wire logic [31:0]                    rsp_power_result,
   input  wire logic                           csr_write,
   input  wire logic [mexp_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]                    csr_data,
   output int unsigned                         fail_count,
   output int unsigned                         outstanding
);

   typedef struct {
      logic [31:0] base;
      logic [31:0] power;
   } power_entry_type;

   // Own copy of the register file
   logic [31:0] cur_modulus;
   logic [31:0] cur_exponent;

   power_entry_type expected_powers[$];
   int unsigned     mismatches;

   // Right-to-left square-and-multiply over 64-bit products
   function automatic logic [31:0] modexp_predict(input logic [31:0] base_in,
                                                  input logic [31:0] modulus_in,
                                                  input logic [31:0] exponent_in);
      logic [63:0] mask;
      logic [63:0] m;
      logic [63:0] e;
      logic [63:0] sq;
      logic [63:0] acc;
      mask = (64'd1 << mexp_pkg::VALUE_BITS) - 64'd1;
      m    = {32'd0, modulus_in} & mask;
      e    = {32'd0, exponent_in} & mask;
      sq   = {32'd0, base_in} & mask;
      acc  = 64'd1;
      if (m < 64'd2) return 32'd0;
      sq = sq % m;
      for (int i = 0; i < mexp_pkg::VALUE_BITS; i++) begin
         if (e[i]) acc = (acc * sq) % m;
         sq = (sq * sq) % m;
      end
      return acc[31:0];
   endfunction

   always @(posedge clock) begin
      power_entry_type entry;
      if (reset) begin
         cur_modulus  = mexp_pkg::MODULUS_RESET;
         cur_exponent = mexp_pkg::EXPONENT_RESET;
         expected_powers.delete();
         mismatches   = 0;
         fail_count  <= 0;
         outstanding <= 0;
      end else begin
         // register writes
         if (csr_write) begin
            if (csr_index == mexp_pkg::CSR_MODULUS) cur_modulus = csr_data;
            else if (csr_index == mexp_pkg::CSR_EXPONENT) cur_exponent = csr_data;
         end
         // input transfer: queue the prediction
         if (req_valid && !req_stall) begin
            entry.base  = req_base_value;
            entry.power = modexp_predict(req_base_value, cur_modulus, cur_exponent);
            expected_powers.push_back(entry);
         end
         // result transfer: compare against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_powers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result %h", $realtime, rsp_power_result);
            end else begin
               entry = expected_powers.pop_front();
               if (rsp_power_result !== entry.power) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: base %h: expected %h, got %h", $realtime,
                              entry.base, entry.power, rsp_power_result);
               end
            end
         end
         fail_count  <= mismatches;
         outstanding <= expected_powers.size();
      end
   end

endmodule

// ===== dv/testbench.sv =====
// Top of the modular exponentiation testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned CYCLE_LIMIT   = 4_000_000;
   localparam int unsigned RANDOM_TARGET = 268;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [31:0]                    req_base_value;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [31:0]                    rsp_power_result;
   logic                           csr_write;
   logic [mexp_pkg::CSR_IDX_W-1:0] csr_index;
   logic [31:0]                    csr_data;

   int unsigned fail_count;
   int unsigned outstanding;

   // Sender and receiver idling controls
   logic        quiet = 1'b0;
   int unsigned stall_left = 0;
   int unsigned stall_pick;
   logic [31:0] cur_mod;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   modular_exponentiation DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_base_value   (req_base_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_power_result (rsp_power_result),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   mexp_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_base_value   (req_base_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_power_result (rsp_power_result),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   // Receiver back-pressure: runs of stall and ready, mostly short, a few long
   always @(posedge clock) begin
      if (quiet) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_pick = $urandom_range(99);
         if (stall_pick < 30) begin
            rsp_stall  <= 1'b1;
            stall_left <= (stall_pick < 3) ? $urandom_range(50, 300) : $urandom_range(0, 3);
         end else begin
            rsp_stall  <= 1'b0;
            stall_left <= $urandom_range(0, 6);
         end
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 4);
      if (r < 97) return $urandom_range(5, 30);
      return $urandom_range(100, 300);
   endfunction

   // One input transfer, then an optional gap with valid low
   task automatic send_base(input logic [31:0] base);
      int unsigned gap;
      req_valid      <= 1'b1;
      req_base_value <= base;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Sender holds off until every queued result has been transferred
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Program both registers with the block idle
   task automatic write_regs(input logic [31:0] modulus, input logic [31:0] exponent);
      drain_results();
      cur_mod   = modulus;
      csr_write <= 1'b1;
      csr_index <= mexp_pkg::CSR_MODULUS;
      csr_data  <= modulus;
      @(posedge clock);
      csr_index <= mexp_pkg::CSR_EXPONENT;
      csr_data  <= exponent;
      @(posedge clock);
      csr_write <= 1'b0;
      csr_data  <= $urandom;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_modulus();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 5)  return 32'd0;
      if (r < 10) return 32'd1;
      if (r < 15) return 32'd2;
      if (r < 25) return 32'hFFFF_FFFF;
      if (r < 30) return 32'h8000_0000;
      if (r < 40) return $urandom_range(3, 1000);
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_exponent();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 8)  return 32'd0;
      if (r < 16) return 32'd1;
      if (r < 26) return 32'hFFFF_FFFF;
      if (r < 36) return $urandom_range(2, 255);
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_base(input logic [31:0] modulus);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 3)  return 32'd0;
      if (r < 6)  return 32'hFFFF_FFFF;
      if (r < 8)  return 32'd1;
      if (r < 11) return modulus;
      if (r < 14) return modulus - 32'd1;
      if (r < 16) return modulus + 32'd1;
      if (r < 40 && modulus != 0) return $urandom % modulus;
      return $urandom;
   endfunction

   initial begin
      int unsigned random_sent;
      int unsigned phase_len;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_base_value <= 32'd0;
      csr_write      <= 1'b0;
      csr_index      <= mexp_pkg::CSR_MODULUS;
      csr_data       <= 32'd0;
      cur_mod         = mexp_pkg::MODULUS_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, around the modulus and the field extremes
      send_base(32'd0);
      send_base(32'd1);
      send_base(32'd256);
      send_base(32'd257);
      send_base(32'd258);
      send_base(32'hFFFF_FFFF);
      // widest modulus and exponent: every square and multiply taken
      write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_base(32'd0);
      send_base(32'hFFFF_FFFE);
      send_base(32'hFFFF_FFFF);
      send_base(32'd2);
      send_base(32'h8000_0000);
      // modulus of zero
      write_regs(32'd0, 32'd5);
      send_base(32'd7);
      // modulus of one
      write_regs(32'd1, 32'hFFFF_FFFF);
      send_base(32'd5);
      send_base(32'hFFFF_FFFF);
      // zero exponent
      write_regs(32'd2, 32'd0);
      send_base(32'd0);
      send_base(32'hFFFF_FFFF);
      write_regs(32'hFFFF_FFFB, 32'd0);
      send_base(32'd12345);
      // only the top exponent bit set
      write_regs(32'd65537, 32'h8000_0000);
      send_base(32'd3);
      send_base(32'hFFFF_FFFF);
      // Fermat: base^(p-1) is 1 unless base is a multiple of p
      write_regs(32'd13, 32'd12);
      send_base(32'd0);
      send_base(32'd13);
      send_base(32'd27);

      // Random phases, each with its own register settings
      random_sent = 0;
      while (random_sent < RANDOM_TARGET) begin
         write_regs(pick_modulus(), pick_exponent());
         quiet     = ($urandom_range(99) < 15);
         phase_len = $urandom_range(8, 30);
         if (phase_len > RANDOM_TARGET - random_sent) phase_len = RANDOM_TARGET - random_sent;
         repeat (phase_len) begin
            if ($urandom_range(99) < 4) drain_results();
            send_base(pick_base(cur_mod));
            random_sent++;
         end
      end
      quiet = 1'b0;

      // Wait for the tail, then watch for stray results
      drain_results();
      repeat (2200) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Run-away guard
   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: failure");
      $finish;
   end

endmodule
